FILE: rtl/btlpm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btlpm_pkg - shared types and codes for the binary trie prefix matcher
// Command and status codes, controller states and the control/status
// bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package btlpm_pkg;

  localparam int NODES_DEF       = 1024;
  localparam int ACTION_BITS_DEF = 8;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam logic [5:0] MAX_DEPTH = 6'd32;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic record;
    logic step_down;
    logic alloc;
    logic wr_add;
    logic wr_clr;
    logic wr_back;
    logic fin_full;
    logic fin_nf;
  } ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       at_end;
    logic       child_zero;
    logic       pool_full;
    logic       node_valid;
    logic       act_match;
  } st_t;

endpackage
`default_nettype wire

FILE: rtl/binary_trie_longest_prefix_match.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary_trie_longest_prefix_match - IPv4 routing table on a binary trie
// Add, remove and longest-prefix lookup over a one-bit-per-level trie.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low. The trie is
// walked one level per clock, one node store access per level. Add and
// remove walk down to the prefix length, capped at 32, ending early when a
// remove meets a missing node or an add finds the pool empty; lookup walks
// until a missing child or depth 32. A new command can start the cycle
// after the result strobe. The result is on the out_ ports in the single
// cycle out_valid is high and must be captured then. The root lives in
// registers and nodes come from a bump allocator, so no clearing pass runs
// after reset.
module binary_trie_longest_prefix_match #(
  parameter int NODES       = btlpm_pkg::NODES_DEF,
  parameter int ACTION_BITS = btlpm_pkg::ACTION_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_command,
  input  wire logic [31:0] in_ip_address,
  input  wire logic [5:0]  in_prefix_len,
  input  wire logic [7:0]  in_action_id,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic             out_hit,
  output logic [7:0]       out_match_action,
  output logic [5:0]       out_match_len
);
  import btlpm_pkg::*;

  ctl_t ctl;
  st_t  st;

  btlpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .st        (st),
    .ctl       (ctl)
  );

  btlpm_dp #(
    .NODES       (NODES),
    .ACTION_BITS (ACTION_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_command       (in_command),
    .in_ip_address    (in_ip_address),
    .in_prefix_len    (in_prefix_len),
    .in_action_id     (in_action_id),
    .ctl              (ctl),
    .st               (st),
    .out_status       (out_status),
    .out_hit          (out_hit),
    .out_match_action (out_match_action),
    .out_match_len    (out_match_len)
  );

endmodule
`default_nettype wire

FILE: rtl/btlpm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btlpm_ctrl - command sequencer
// Walks the trie one level per cycle and decides at each level whether to
// descend, allocate, write the final node or finish.
// ----------------------------------------------------------------------------
module btlpm_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  output logic                  out_valid,
  input  wire btlpm_pkg::st_t   st,
  output btlpm_pkg::ctl_t       ctl
);
  import btlpm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        unique case (st.cmd)
          CMD_LOOKUP: begin
            ctl.record = 1'b1;
            if (st.at_end || st.child_zero) begin
              state_nxt = S_RESP;
            end else begin
              ctl.step_down = 1'b1;
            end
          end
          CMD_REMOVE: begin
            if (st.at_end) begin
              if (st.node_valid && st.act_match) begin
                ctl.wr_clr = 1'b1;
              end else begin
                ctl.fin_nf = 1'b1;
              end
              state_nxt = S_RESP;
            end else if (st.child_zero) begin
              ctl.fin_nf = 1'b1;
              state_nxt  = S_RESP;
            end else begin
              ctl.step_down = 1'b1;
            end
          end
          CMD_ADD: begin
            if (st.at_end) begin
              ctl.wr_add = 1'b1;
              state_nxt  = S_RESP;
            end else if (!st.child_zero) begin
              ctl.step_down = 1'b1;
            end else if (st.pool_full) begin
              // fresh path node must still land in memory
              ctl.wr_back  = 1'b1;
              ctl.fin_full = 1'b1;
              state_nxt    = S_RESP;
            end else begin
              ctl.alloc = 1'b1;
            end
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end
      S_RESP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESP);

  a_strobe_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_single_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.step_down, ctl.alloc, ctl.wr_add, ctl.wr_clr, ctl.wr_back}))
    else $error("more than one node store operation in a cycle");

endmodule
`default_nettype wire

FILE: rtl/btlpm_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btlpm_dp - trie datapath
// Node store, root node registers, bump allocator, walk registers and the
// result registers.
// ----------------------------------------------------------------------------
module btlpm_dp #(
  parameter int NODES       = btlpm_pkg::NODES_DEF,
  parameter int ACTION_BITS = btlpm_pkg::ACTION_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [1:0]       in_command,
  input  wire logic [31:0]      in_ip_address,
  input  wire logic [5:0]       in_prefix_len,
  input  wire logic [7:0]       in_action_id,
  input  wire btlpm_pkg::ctl_t  ctl,
  output btlpm_pkg::st_t        st,
  output logic [1:0]            out_status,
  output logic                  out_hit,
  output logic [7:0]            out_match_action,
  output logic [5:0]            out_match_len
);
  import btlpm_pkg::*;

  localparam int IW  = $clog2(NODES);
  localparam int NFW = $clog2(NODES + 1);

  typedef struct packed {
    logic                   valid;
    logic [ACTION_BITS-1:0] action;
    logic [IW-1:0]          c0;
    logic [IW-1:0]          c1;
  } node_t;

  node_t mem [NODES];
  node_t mem_q;

  node_t                  root_r;
  node_t                  node_r;
  logic                   src_mem_r;
  logic [NFW-1:0]         next_free_r;
  logic [IW-1:0]          cur_idx_r;
  logic [1:0]             cmd_r;
  logic [31:0]            addr_r;
  logic [5:0]             len_r;
  logic [5:0]             depth_r;
  logic [ACTION_BITS-1:0] act_r;

  logic [1:0]             status_r;
  logic                   hit_r;
  logic [ACTION_BITS-1:0] mact_r;
  logic [5:0]             mlen_r;

  node_t         cur;
  node_t         wr_data;
  logic [IW-1:0] child;
  logic          wr_en;

  assign cur   = src_mem_r ? mem_q : node_r;
  assign child = addr_r[31] ? cur.c1 : cur.c0;
  assign wr_en = ctl.alloc | ctl.wr_add | ctl.wr_clr | ctl.wr_back;

  always_comb begin
    wr_data = cur;
    if (ctl.alloc) begin
      if (addr_r[31]) begin
        wr_data.c1 = next_free_r[IW-1:0];
      end else begin
        wr_data.c0 = next_free_r[IW-1:0];
      end
    end
    if (ctl.wr_add) begin
      wr_data.valid  = 1'b1;
      wr_data.action = act_r;
    end
    if (ctl.wr_clr) begin
      wr_data.valid = 1'b0;
    end
  end

  always_comb begin
    st.cmd        = cmd_r;
    st.at_end     = (cmd_r == CMD_LOOKUP) ? (depth_r == MAX_DEPTH) : (depth_r == len_r);
    st.child_zero = (child == '0);
    st.pool_full  = (next_free_r == NFW'(NODES));
    st.node_valid = cur.valid;
    st.act_match  = (cur.action == act_r);
  end

  // node store: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en && (cur_idx_r != '0)) begin
      mem[cur_idx_r] <= wr_data;
    end
    if (ctl.step_down) begin
      mem_q <= mem[child];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r      <= '0;
      next_free_r <= NFW'(1);
      src_mem_r   <= 1'b0;
    end else begin
      if (wr_en && (cur_idx_r == '0)) begin
        root_r <= wr_data;
      end
      if (ctl.load) begin
        src_mem_r <= 1'b0;
      end else if (ctl.step_down) begin
        src_mem_r <= 1'b1;
      end else if (ctl.alloc) begin
        src_mem_r <= 1'b0;
      end
      if (ctl.alloc) begin
        next_free_r <= next_free_r + NFW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r     <= in_command;
      addr_r    <= in_ip_address;
      len_r     <= (in_prefix_len > MAX_DEPTH) ? MAX_DEPTH : in_prefix_len;
      act_r     <= ACTION_BITS'(in_action_id);
      depth_r   <= '0;
      cur_idx_r <= '0;
      node_r    <= root_r;
    end else if (ctl.step_down) begin
      addr_r    <= {addr_r[30:0], 1'b0};
      depth_r   <= depth_r + 6'd1;
      cur_idx_r <= child;
    end else if (ctl.alloc) begin
      addr_r    <= {addr_r[30:0], 1'b0};
      depth_r   <= depth_r + 6'd1;
      cur_idx_r <= next_free_r[IW-1:0];
      node_r    <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      status_r <= ST_OK;
      hit_r    <= 1'b0;
      mact_r   <= '0;
      mlen_r   <= '0;
    end else begin
      if (ctl.record && cur.valid) begin
        hit_r  <= 1'b1;
        mact_r <= cur.action;
        mlen_r <= depth_r;
      end
      if (ctl.fin_full) begin
        status_r <= ST_FULL;
      end
      if (ctl.fin_nf) begin
        status_r <= ST_NOT_FOUND;
      end
    end
  end

  assign out_status       = status_r;
  assign out_hit          = hit_r;
  assign out_match_action = 8'(mact_r);
  assign out_match_len    = mlen_r;

  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    (next_free_r <= NFW'(NODES)) && (next_free_r != '0))
    else $error("allocator pointer out of range");

  a_alloc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.alloc |-> !st.pool_full)
    else $error("node allocated from an exhausted pool");

  a_descend_real_child: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.step_down |-> !st.child_zero)
    else $error("descent through a missing child");

endmodule
`default_nettype wire

FILE: tb/sv/binary_trie_longest_prefix_match_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_trie_longest_prefix_match_tb - prefix table regression
// Directed beats cover an empty table, /0 and /32 routes, saturated lengths,
// re-adds and failed removes. RANDOM_BEATS of clustered random add, remove,
// lookup and unused-command traffic follow. Each result beat is checked
// against its directed row's typed result or a trie predictor in this bench.
// ----------------------------------------------------------------------------
module binary_trie_longest_prefix_match_tb;
  import btlpm_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int TRIE_NODES    = NODES_DEF;
  localparam int DIRECTED_BEATS = 25;
  localparam int RANDOM_BEATS   = 850;
  localparam int QUIET_TAIL     = 150;

  typedef struct packed {
    logic [1:0] status;
    logic       hit;
    logic [7:0] action;
    logic [5:0] len;
  } route_rsp_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] addr;
    logic [5:0]  plen;
    logic [7:0]  act;
    logic        typed;
    route_rsp_t  rsp;
  } route_row_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [5:0]  plen;
    logic [7:0]  act;
  } route_entry_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_command;
  logic [31:0] in_ip_address;
  logic [5:0]  in_prefix_len;
  logic [7:0]  in_action_id;
  logic        out_valid;
  logic [1:0]  out_status;
  logic        out_hit;
  logic [7:0]  out_match_action;
  logic [5:0]  out_match_len;

  bit          trie_valid  [TRIE_NODES];
  logic [7:0]  trie_action [TRIE_NODES];
  int unsigned trie_kid0   [TRIE_NODES];
  int unsigned trie_kid1   [TRIE_NODES];
  int unsigned trie_next_free;

  route_rsp_t   route_due [$];
  route_entry_t known_routes [$];
  int           mismatch_count = 0;

  binary_trie_longest_prefix_match dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_ip_address    (in_ip_address),
    .in_prefix_len    (in_prefix_len),
    .in_action_id     (in_action_id),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_hit          (out_hit),
    .out_match_action (out_match_action),
    .out_match_len    (out_match_len)
  );

  always #4 clk = ~clk;

  function automatic route_rsp_t route_predict(input logic [1:0] cmd, input logic [31:0] addr,
                                               input logic [5:0] plen, input logic [7:0] act);
    route_rsp_t  r;
    int unsigned lim, cur, nxt, d;
    bit          b, full, found, walking;
    r = '0;
    cur = 0;
    lim = (plen > 6'd32) ? 32 : plen;
    case (cmd)
      CMD_ADD: begin
        full = 1'b0;
        for (d = 0; d < lim && !full; d++) begin
          b = addr[31 - d];
          nxt = b ? trie_kid1[cur] : trie_kid0[cur];
          if (nxt == 0) begin
            if (trie_next_free >= TRIE_NODES) begin
              full = 1'b1;
            end else begin
              nxt = trie_next_free;
              trie_next_free++;
              trie_valid[nxt]  = 1'b0;
              trie_action[nxt] = '0;
              trie_kid0[nxt]   = 0;
              trie_kid1[nxt]   = 0;
              if (b) trie_kid1[cur] = nxt;
              else trie_kid0[cur] = nxt;
            end
          end
          if (!full) cur = nxt;
        end
        if (full) begin
          r.status = ST_FULL;
        end else begin
          trie_valid[cur]  = 1'b1;
          trie_action[cur] = act;
        end
      end
      CMD_REMOVE: begin
        found = 1'b1;
        for (d = 0; d < lim && found; d++) begin
          nxt = addr[31 - d] ? trie_kid1[cur] : trie_kid0[cur];
          if (nxt == 0) found = 1'b0;
          else cur = nxt;
        end
        if (found && trie_valid[cur] && trie_action[cur] == act) trie_valid[cur] = 1'b0;
        else r.status = ST_NOT_FOUND;
      end
      CMD_LOOKUP: begin
        d = 0;
        walking = 1'b1;
        while (walking) begin
          if (trie_valid[cur]) begin
            r.hit    = 1'b1;
            r.action = trie_action[cur];
            r.len    = 6'(d);
          end
          if (d >= 32) begin
            walking = 1'b0;
          end else begin
            nxt = addr[31 - d] ? trie_kid1[cur] : trie_kid0[cur];
            if (nxt == 0) begin
              walking = 1'b0;
            end else begin
              cur = nxt;
              d++;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // directed table: typed rows carry their expected result, others use the predictor
  function automatic route_row_t directed_row(input int idx);
    case (idx)
      0:  return {CMD_LOOKUP, 32'h0000_0000, 6'd0, 8'h00, 1'b1, ST_OK, 1'b0, 8'h00, 6'd0};
      1:  return {CMD_REMOVE, 32'h0000_0000, 6'd0, 8'h00, 1'b1, ST_NOT_FOUND, 1'b0, 8'h00, 6'd0};
      2:  return {CMD_UNUSED, 32'hFFFF_FFFF, 6'd63, 8'hFF, 1'b1, ST_OK, 1'b0, 8'h00, 6'd0};
      3:  return {CMD_ADD, 32'h0000_0000, 6'd0, 8'hFF, 1'b1, ST_OK, 1'b0, 8'h00, 6'd0};
      4:  return {CMD_LOOKUP, 32'h1234_5678, 6'd0, 8'h00, 1'b1, ST_OK, 1'b1, 8'hFF, 6'd0};
      5:  return {CMD_ADD, 32'hFFFF_FFFF, 6'd32, 8'h5A, 1'b1, ST_OK, 1'b0, 8'h00, 6'd0};
      6:  return {CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0, 8'h00, 1'b1, ST_OK, 1'b1, 8'h5A, 6'd32};
      7:  return {CMD_LOOKUP, 32'hFFFF_FFFE, 6'd0, 8'h00, 1'b1, ST_OK, 1'b1, 8'hFF, 6'd0};
      8:  return {CMD_ADD, 32'h0000_0000, 6'd63, 8'h01, 1'b1, ST_OK, 1'b0, 8'h00, 6'd0};
      9:  return {CMD_LOOKUP, 32'h0000_0000, 6'd0, 8'h00, 1'b1, ST_OK, 1'b1, 8'h01, 6'd32};
      10: return {CMD_ADD, 32'h0A00_0000, 6'd8, 8'h00, 1'b1, ST_OK, 1'b0, 8'h00, 6'd0};
      11: return {CMD_LOOKUP, 32'h0A0B_0C0D, 6'd0, 8'h00, 1'b1, ST_OK, 1'b1, 8'h00, 6'd8};
      12: return {CMD_REMOVE, 32'h0A00_0000, 6'd8, 8'h07, 1'b1, ST_NOT_FOUND, 1'b0, 8'h00, 6'd0};
      13: return {CMD_REMOVE, 32'h0A00_0000, 6'd8, 8'h00, 1'b1, ST_OK, 1'b0, 8'h00, 6'd0};
      14: return {CMD_REMOVE, 32'h0A00_0000, 6'd8, 8'h00, 1'b1, ST_NOT_FOUND, 1'b0, 8'h00, 6'd0};
      15: return {CMD_LOOKUP, 32'h0A0B_0C0D, 6'd0, 8'h00, 1'b1, ST_OK, 1'b1, 8'hFF, 6'd0};
      16: return {CMD_ADD, 32'hC0A8_0000, 6'd16, 8'h80, 1'b1, ST_OK, 1'b0, 8'h00, 6'd0};
      17: return {CMD_ADD, 32'hC0A8_0000, 6'd16, 8'h7F, 1'b1, ST_OK, 1'b0, 8'h00, 6'd0};
      18: return {CMD_LOOKUP, 32'hC0A8_FFFF, 6'd40, 8'hAA, 1'b0, 17'd0};
      19: return {CMD_REMOVE, 32'hC0A8_0100, 6'd24, 8'h7F, 1'b1, ST_NOT_FOUND, 1'b0, 8'h00, 6'd0};
      20: return {CMD_ADD, 32'hC0A8_0100, 6'd24, 8'h33, 1'b0, 17'd0};
      21: return {CMD_LOOKUP, 32'hC0A8_0155, 6'd0, 8'h00, 1'b0, 17'd0};
      22: return {CMD_REMOVE, 32'h0000_0000, 6'd0, 8'hFF, 1'b1, ST_OK, 1'b0, 8'h00, 6'd0};
      23: return {CMD_LOOKUP, 32'h1234_5678, 6'd0, 8'h00, 1'b1, ST_OK, 1'b0, 8'h00, 6'd0};
      24: return {CMD_LOOKUP, 32'hFFFF_FFFF, 6'd17, 8'h55, 1'b0, 17'd0};
      default: return '0;
    endcase
  endfunction

  // most traffic lands in four /6 clusters so paths share nodes
  function automatic logic [31:0] cluster_addr();
    logic [31:0] a;
    a = $urandom;
    if ($urandom_range(0, 3) != 0) a[31:26] = 6'($urandom_range(0, 3));
    return a;
  endfunction

  function automatic logic [5:0] pick_plen();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return 6'($urandom_range(0, 16));
    if (r < 9) return 6'($urandom_range(17, 32));
    return 6'($urandom_range(33, 63));
  endfunction

  task automatic issue_beat(input logic [1:0] cmd, input logic [31:0] addr,
                            input logic [5:0] plen, input logic [7:0] act,
                            input bit typed, input route_rsp_t typed_rsp, input bit may_idle);
    route_rsp_t model_rsp;
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start         <= 1'b1;
    in_command    <= cmd;
    in_ip_address <= addr;
    in_prefix_len <= plen;
    in_action_id  <= act;
    do @(posedge clk); while (busy !== 1'b0);
    model_rsp = route_predict(cmd, addr, plen, act);
    route_due.push_back(typed ? typed_rsp : model_rsp);
  endtask

  always @(posedge clk) begin : rsp_check
    route_rsp_t due;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (route_due.size() == 0) begin
        $error("result beat with nothing outstanding");
        mismatch_count++;
      end else begin
        due = route_due.pop_front();
        if (out_status !== due.status) begin
          $error("status: expected %0d, got %0d", due.status, out_status);
          mismatch_count++;
        end
        if (out_hit !== due.hit) begin
          $error("hit: expected %0d, got %0d", due.hit, out_hit);
          mismatch_count++;
        end
        if (out_match_action !== due.action) begin
          $error("match_action: expected %0d, got %0d", due.action, out_match_action);
          mismatch_count++;
        end
        if (out_match_len !== due.len) begin
          $error("match_len: expected %0d, got %0d", due.len, out_match_len);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    route_row_t   row;
    route_entry_t ent;
    logic [1:0]   cmd;
    logic [31:0]  addr, keep;
    logic [5:0]   plen;
    logic [7:0]   act;
    int unsigned  pick, sel, depth;
    int           n;

    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_command    <= CMD_ADD;
    in_ip_address <= '0;
    in_prefix_len <= '0;
    in_action_id  <= '0;
    trie_valid[0]  = 1'b0;
    trie_action[0] = '0;
    trie_kid0[0]   = 0;
    trie_kid1[0]   = 0;
    trie_next_free = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < DIRECTED_BEATS; n++) begin
      row = directed_row(n);
      issue_beat(row.cmd, row.addr, row.plen, row.act, row.typed, row.rsp, 1'b1);
    end

    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (n == RANDOM_BEATS / 2) begin
        start <= 1'b0;
        @(posedge clk);
        while (route_due.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(0, 19);
      act  = 8'($urandom_range(0, 255));
      if (pick < 7) begin
        cmd  = CMD_ADD;
        addr = cluster_addr();
        plen = pick_plen();
        known_routes.push_back({addr, plen, act});
        if (known_routes.size() > 64) ent = known_routes.pop_front();
      end else if (pick < 11) begin
        cmd = CMD_REMOVE;
        sel = $urandom_range(0, 4);
        if (known_routes.size() == 0 || sel == 0) begin
          addr = cluster_addr();
          plen = pick_plen();
        end else begin
          ent  = known_routes[$urandom_range(0, known_routes.size() - 1)];
          addr = ent.addr;
          plen = ent.plen;
          act  = (sel == 4) ? (ent.act ^ 8'($urandom_range(1, 255))) : ent.act;
        end
      end else if (pick < 19) begin
        cmd  = CMD_LOOKUP;
        plen = 6'($urandom_range(0, 63));
        if (known_routes.size() == 0 || $urandom_range(0, 4) < 2) begin
          addr = $urandom_range(0, 1) ? cluster_addr() : $urandom;
        end else begin
          // land inside a known prefix, random tail
          ent   = known_routes[$urandom_range(0, known_routes.size() - 1)];
          depth = (ent.plen > 6'd32) ? 32 : ent.plen;
          keep  = (depth == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - depth));
          addr  = (ent.addr & keep) | ($urandom & ~keep);
        end
      end else begin
        cmd  = CMD_UNUSED;
        addr = $urandom;
        plen = 6'($urandom_range(0, 63));
      end
      issue_beat(cmd, addr, plen, act, 1'b0, '0, n < RANDOM_BEATS - QUIET_TAIL);
    end

    start <= 1'b0;
    while (route_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/btlpm_pkg.sv
rtl/btlpm_ctrl.sv
rtl/btlpm_dp.sv
rtl/binary_trie_longest_prefix_match.sv
tb/sv/binary_trie_longest_prefix_match_tb.sv
